// ===== rtl/fspae_pkg.sv =====
// ----------------------------------------------------------------------------
// fspae_pkg: shared types and constants of the superpage address expander
// Holds the channel payloads, sequencer states, divider handshake structs,
// register indexes and dimension codes.
// ----------------------------------------------------------------------------
package fspae_pkg;

   localparam int unsigned SUPERPAGE_MAX  = 64;
   localparam int unsigned MASK_WIDTH     = 64;
   localparam int unsigned BLOCK_WIDTH    = 32;
   localparam int unsigned PAGE_WIDTH     = 16;
   localparam int unsigned COORD_WIDTH    = 6;
   localparam int unsigned COUNT_WIDTH    = 7;
   localparam int unsigned NUM_DIMS       = 4;
   localparam int unsigned CSR_IDX_WIDTH  = 3;
   localparam int unsigned CSR_DATA_WIDTH = 8;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 7'd64;
   localparam logic [COUNT_WIDTH-1:0] LIMIT_MAX = COUNT_WIDTH'(SUPERPAGE_MAX);
   localparam logic [CSR_DATA_WIDTH-1:0] ORDER_MASK = 8'hFF;

   // dimension codes
   localparam logic [1:0] DIM_CHANNEL = 2'd0;
   localparam logic [1:0] DIM_PACKAGE = 2'd1;
   localparam logic [1:0] DIM_DIE     = 2'd2;
   localparam logic [1:0] DIM_PLANE   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ALLOC_ORDER     = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SUPERBLOCK_MASK = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MULTIPLANE      = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_USE_IO_MASK     = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CHANNEL_COUNT   = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PACKAGE_COUNT   = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIE_COUNT       = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PLANE_COUNT     = 3'd7;

   typedef struct packed {
      logic [BLOCK_WIDTH-1:0] block_index;
      logic [PAGE_WIDTH-1:0]  page_index;
      logic [MASK_WIDTH-1:0]  page_mask;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] channel;
      logic [COORD_WIDTH-1:0] package_res;
      logic [COORD_WIDTH-1:0] die;
      logic [COORD_WIDTH-1:0] plane;
      logic [BLOCK_WIDTH-1:0] block;
      logic [PAGE_WIDTH-1:0]  page;
      logic                   last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_DIV,
      ST_TRIM,
      ST_ENUM
   } state_type;

   typedef struct packed {
      logic                   start;
      logic [BLOCK_WIDTH-1:0] dividend;
      logic [COUNT_WIDTH-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic [BLOCK_WIDTH-1:0] quotient;
      logic [COORD_WIDTH-1:0] remainder;
   } div_status_type;

   // zero acts as one, anything above the range as the maximum
   function automatic logic [COUNT_WIDTH-1:0] clamp_count(input logic [COUNT_WIDTH-1:0] c);
      logic [COUNT_WIDTH-1:0] r;
      r = c;
      if (c == '0) begin
         r = COUNT_WIDTH'(1);
      end else if (c > COUNT_MAX) begin
         r = COUNT_MAX;
      end
      return r;
   endfunction

endpackage

// ===== rtl/fspae_req_if.sv =====
// ----------------------------------------------------------------------------
// fspae_req_if: request channel
// Valid/ready channel that carries one block/page/mask request.
// ----------------------------------------------------------------------------
interface fspae_req_if;
   logic                       valid;
   logic                       ready;
   fspae_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/fspae_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fspae_rsp_if: response channel
// Valid/ready channel that carries one physical page address.
// ----------------------------------------------------------------------------
interface fspae_rsp_if;
   logic                       valid;
   logic                       ready;
   fspae_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/flash_superpage_address_expander_top.sv =====
// ----------------------------------------------------------------------------
// flash_superpage_address_expander_top: superpage address expander
// Splits a block index into channel/package/die/plane, enumerates superblock
// dimensions and emits one physical address per selected superpage position.
// ----------------------------------------------------------------------------
// sequence: the order slots in turn, a division in the shared bit-serial divider
//   per divided dimension, a trim step, one step per mask position up to the
//   last selected one, then back to idle (rsp stalls hold the enumeration)
// requests: one at a time; a new request is taken only while idle
// reset: synchronous, active high; control and configuration registers return
//   to their reset values and the sequencer goes idle with no pending transfer
module flash_superpage_address_expander_top (
   input  logic                                    clock,
   input  logic                                    reset,
   fspae_req_if.sink                               req_chan,
   fspae_rsp_if.source                             rsp_chan,
   input  logic                                    csr_write_enable,
   input  logic [fspae_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [fspae_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   localparam int unsigned CW = fspae_pkg::COORD_WIDTH;
   localparam int unsigned NW = fspae_pkg::COUNT_WIDTH;
   localparam int unsigned MW = fspae_pkg::MASK_WIDTH;
   localparam int unsigned ND = fspae_pkg::NUM_DIMS;

   // configuration
   logic [7:0]            alloc_order_ff;
   logic [ND-1:0]         superblock_mask_ff;
   logic                  multiplane_ff;
   logic                  use_io_mask_ff;
   logic [NW-1:0]         count_ff [ND];

   // sequencer and work registers
   fspae_pkg::state_type              state_ff, state_in;
   logic [1:0]                        slot_ff, slot_in;
   logic [fspae_pkg::BLOCK_WIDTH-1:0] rem_ff, rem_in;
   logic [fspae_pkg::PAGE_WIDTH-1:0]  page_ff, page_in;
   logic [MW-1:0]                     mask_ff, mask_in;
   logic [CW-1:0]                     coord_ff [ND];
   logic [CW-1:0]                     coord_in [ND];
   logic [1:0]                        en_dim_ff [ND];
   logic [1:0]                        en_dim_in [ND];
   logic [NW-1:0]                     en_cnt_ff [ND];
   logic [NW-1:0]                     en_cnt_in [ND];
   logic [2:0]                        n_en_ff, n_en_in;
   logic [NW-1:0]                     prod_ff, prod_in;
   logic [CW-1:0]                     digit_ff [ND];
   logic [CW-1:0]                     digit_in [ND];

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   fspae_pkg::rsp_payload_type   rsp_data_ff, rsp_data_in;

   fspae_pkg::div_ctrl_type      div_ctrl;
   fspae_pkg::div_status_type    div_status;

   logic [1:0]          slot_dim;
   logic [NW-1:0]       slot_cnt;
   logic [2*NW-1:0]     prod_wide;
   logic [CW-1:0]       cur_coord [ND];
   logic                carry;
   logic                out_free;
   logic                req_xfer;

   fspae_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (div_ctrl),
      .status (div_status)
   );

   assign req_chan.ready   = (state_ff == fspae_pkg::ST_IDLE);
   assign req_xfer         = req_chan.valid && (state_ff == fspae_pkg::ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;
   assign out_free         = !rsp_valid_ff || rsp_chan.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_order_ff     <= 8'd228;
         superblock_mask_ff <= '0;
         multiplane_ff      <= 1'b0;
         use_io_mask_ff     <= 1'b0;
         count_ff[0]        <= NW'(8);
         count_ff[1]        <= NW'(4);
         count_ff[2]        <= NW'(2);
         count_ff[3]        <= NW'(2);
      end else if (csr_write_enable) begin
         case (csr_index)
            fspae_pkg::CSR_ALLOC_ORDER: begin
               alloc_order_ff <= csr_write_data & fspae_pkg::ORDER_MASK;
            end
            fspae_pkg::CSR_SUPERBLOCK_MASK: begin
               superblock_mask_ff <= csr_write_data[ND-1:0];
            end
            fspae_pkg::CSR_MULTIPLANE: begin
               multiplane_ff <= csr_write_data[0];
            end
            fspae_pkg::CSR_USE_IO_MASK: begin
               use_io_mask_ff <= csr_write_data[0];
            end
            fspae_pkg::CSR_CHANNEL_COUNT: begin
               count_ff[fspae_pkg::DIM_CHANNEL] <= csr_write_data[NW-1:0];
            end
            fspae_pkg::CSR_PACKAGE_COUNT: begin
               count_ff[fspae_pkg::DIM_PACKAGE] <= csr_write_data[NW-1:0];
            end
            fspae_pkg::CSR_DIE_COUNT: begin
               count_ff[fspae_pkg::DIM_DIE] <= csr_write_data[NW-1:0];
            end
            fspae_pkg::CSR_PLANE_COUNT: begin
               count_ff[fspae_pkg::DIM_PLANE] <= csr_write_data[NW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      slot_dim  = alloc_order_ff[2*slot_ff +: 2];
      slot_cnt  = fspae_pkg::clamp_count(count_ff[slot_dim]);
      prod_wide = (2*NW)'(prod_ff) * (2*NW)'(slot_cnt);

      // coordinates of the current enumeration position; later slots win
      for (int d = 0; d < ND; d++) begin
         cur_coord[d] = coord_ff[d];
      end
      for (int i = 0; i < ND; i++) begin
         if (3'(i) < n_en_ff) begin
            cur_coord[en_dim_ff[i]] = digit_ff[i];
         end
      end

      state_in     = state_ff;
      slot_in      = slot_ff;
      rem_in       = rem_ff;
      page_in      = page_ff;
      mask_in      = mask_ff;
      n_en_in      = n_en_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      for (int d = 0; d < ND; d++) begin
         coord_in[d]  = coord_ff[d];
         en_dim_in[d] = en_dim_ff[d];
         en_cnt_in[d] = en_cnt_ff[d];
         digit_in[d]  = digit_ff[d];
      end
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = rem_ff;
      div_ctrl.divisor  = slot_cnt;

      // mixed-radix increment, first enumerated slot fastest
      carry = 1'b1;
      for (int i = 0; i < ND; i++) begin
         if (carry) begin
            if (NW'(digit_ff[i]) + NW'(1) == en_cnt_ff[i]) begin
               digit_in[i] = '0;
            end else begin
               digit_in[i] = digit_ff[i] + CW'(1);
               carry       = 1'b0;
            end
         end
      end
      // the increment only takes effect on a position step
      if (state_ff != fspae_pkg::ST_ENUM) begin
         for (int d = 0; d < ND; d++) begin
            digit_in[d] = digit_ff[d];
         end
      end

      case (state_ff)
         fspae_pkg::ST_IDLE: begin
            if (req_xfer) begin
               rem_in  = req_chan.payload.block_index;
               page_in = req_chan.payload.page_index;
               mask_in = use_io_mask_ff ? req_chan.payload.page_mask : '1;
               n_en_in = '0;
               prod_in = NW'(1);
               slot_in = '0;
               for (int d = 0; d < ND; d++) begin
                  coord_in[d] = '0;
                  digit_in[d] = '0;
               end
               state_in = fspae_pkg::ST_SLOT;
            end
         end
         fspae_pkg::ST_SLOT: begin
            if (slot_dim == fspae_pkg::DIM_PLANE && multiplane_ff) begin
               slot_in  = slot_ff + 2'd1;
               state_in = (slot_ff == 2'd3) ? fspae_pkg::ST_TRIM : fspae_pkg::ST_SLOT;
            end else if (superblock_mask_ff[slot_dim]) begin
               en_dim_in[n_en_ff[1:0]] = slot_dim;
               en_cnt_in[n_en_ff[1:0]] = slot_cnt;
               n_en_in  = n_en_ff + 3'd1;
               prod_in  = (prod_wide > (2*NW)'(fspae_pkg::LIMIT_MAX)) ?
                          fspae_pkg::LIMIT_MAX : prod_wide[NW-1:0];
               slot_in  = slot_ff + 2'd1;
               state_in = (slot_ff == 2'd3) ? fspae_pkg::ST_TRIM : fspae_pkg::ST_SLOT;
            end else begin
               div_ctrl.start = 1'b1;
               state_in       = fspae_pkg::ST_DIV;
            end
         end
         fspae_pkg::ST_DIV: begin
            if (div_status.done) begin
               coord_in[slot_dim] = div_status.remainder;
               rem_in   = div_status.quotient;
               slot_in  = slot_ff + 2'd1;
               state_in = (slot_ff == 2'd3) ? fspae_pkg::ST_TRIM : fspae_pkg::ST_SLOT;
            end
         end
         fspae_pkg::ST_TRIM: begin
            // drop positions at or beyond the enumeration size
            for (int i = 0; i < MW; i++) begin
               mask_in[i] = mask_ff[i] && (NW'(i) < prod_ff);
            end
            state_in = fspae_pkg::ST_ENUM;
         end
         fspae_pkg::ST_ENUM: begin
            if (mask_ff == '0) begin
               state_in = fspae_pkg::ST_IDLE;
            end else if (!mask_ff[0]) begin
               mask_in = {1'b0, mask_ff[MW-1:1]};
            end else if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.channel     = cur_coord[fspae_pkg::DIM_CHANNEL];
               rsp_data_in.package_res = cur_coord[fspae_pkg::DIM_PACKAGE];
               rsp_data_in.die         = cur_coord[fspae_pkg::DIM_DIE];
               rsp_data_in.plane       = cur_coord[fspae_pkg::DIM_PLANE];
               rsp_data_in.block       = rem_ff;
               rsp_data_in.page        = page_ff;
               rsp_data_in.last        = (mask_ff[MW-1:1] == '0);
               mask_in                 = {1'b0, mask_ff[MW-1:1]};
            end else begin
               // hold the position while the output register is full
               for (int d = 0; d < ND; d++) begin
                  digit_in[d] = digit_ff[d];
               end
            end
         end
         default: begin
            state_in = fspae_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fspae_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
         n_en_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         n_en_ff      <= n_en_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      page_ff     <= page_in;
      mask_ff     <= mask_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      for (int d = 0; d < ND; d++) begin
         coord_ff[d]  <= coord_in[d];
         en_dim_ff[d] <= en_dim_in[d];
         en_cnt_ff[d] <= en_cnt_in[d];
         digit_ff[d]  <= digit_in[d];
      end
   end

endmodule

// ===== rtl/fspae_divider.sv =====
// ----------------------------------------------------------------------------
// fspae_divider: bit-serial block index divider
// Restoring division of the 32-bit block index by a count of 1 to 64,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fspae_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  fspae_pkg::div_ctrl_type    ctrl,
   output fspae_pkg::div_status_type  status
);

   localparam int unsigned STEP_WIDTH = $clog2(fspae_pkg::BLOCK_WIDTH + 1);
   localparam logic [STEP_WIDTH-1:0] STEP_COUNT = STEP_WIDTH'(fspae_pkg::BLOCK_WIDTH);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [STEP_WIDTH-1:0]                 step_ff, step_in;
   logic [fspae_pkg::COORD_WIDTH-1:0]     rem_ff, rem_in;
   logic [fspae_pkg::BLOCK_WIDTH-1:0]     quo_ff, quo_in;
   logic [fspae_pkg::COUNT_WIDTH-1:0]     divisor_ff, divisor_in;

   logic [fspae_pkg::COUNT_WIDTH-1:0]     shifted;
   logic [fspae_pkg::COUNT_WIDTH-1:0]     diff;
   logic                                  fits;

   always_comb begin
      shifted    = {rem_ff, quo_ff[fspae_pkg::BLOCK_WIDTH-1]};
      fits       = (shifted >= divisor_ff);
      diff       = shifted - divisor_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (ctrl.start) begin
         busy_in    = 1'b1;
         step_in    = STEP_COUNT;
         rem_in     = '0;
         quo_in     = ctrl.dividend;
         divisor_in = ctrl.divisor;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so six bits hold it
         rem_in  = fits ? diff[fspae_pkg::COORD_WIDTH-1:0]
                        : shifted[fspae_pkg::COORD_WIDTH-1:0];
         quo_in  = {quo_ff[fspae_pkg::BLOCK_WIDTH-2:0], fits};
         step_in = step_ff - STEP_WIDTH'(1);
         if (step_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy      = busy_ff;
   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

endmodule
